### rtl/core/pst_pkg.sv
// ----------------------------------------------------------------------------
// PID set table package
// Shared widths, operation codes and controller states for the PID set table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pst_pkg;

   localparam int PID_W               = 13;
   localparam int IDX_W               = 5;
   localparam int OP_W                = 2;
   localparam int CNT_OUT_W           = 6;
   localparam int DEFAULT_MAX_ENTRIES = 32;

   typedef enum logic [OP_W-1:0] {
      OP_LOOKUP = 2'd0,
      OP_ADD    = 2'd1,
      OP_REMOVE = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_RD_WAIT,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

### rtl/core/pst_ram.sv
// ----------------------------------------------------------------------------
// PID set table RAM
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pst_ram #(
   parameter int WIDTH  = 13,
   parameter int DEPTH  = 32,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/core/pid_set_table.sv
// ----------------------------------------------------------------------------
// PID set table
// Ordered set of unique 13-bit PIDs held in a RAM, with lookup, add, remove
// and indexed read operations.
// ----------------------------------------------------------------------------
// One operation is taken at a time: start is accepted while busy is low, and
// busy stays high until the result beat has been issued. Every operation
// first scans the stored entries through the single RAM read port, one entry
// a cycle. A remove that hits stops its scan at the match and then moves
// every later entry down one place, again one entry a cycle, so the scan
// and the shift together cover all N stored PIDs. The result beat is shown
// for exactly one cycle on rsp_valid; the receiver cannot stall it. No
// clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pid_set_table #(
   parameter int MAX_ENTRIES = pst_pkg::DEFAULT_MAX_ENTRIES
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [pst_pkg::OP_W-1:0]      req_opcode,
   input  wire logic [pst_pkg::PID_W-1:0]     req_pid,
   input  wire logic [pst_pkg::IDX_W-1:0]     req_entry_index,
   output logic                               rsp_valid,
   output logic                               rsp_was_present,
   output logic                               rsp_rejected_full,
   output logic [pst_pkg::CNT_OUT_W-1:0]      rsp_entry_count,
   output logic [pst_pkg::PID_W-1:0]          rsp_read_value,
   output logic                               rsp_read_valid
);

   localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W = CNT_W + pst_pkg::IDX_W;

   pst_pkg::state_type state_ff, state_in;
   pst_pkg::op_type    op_ff, op_in;

   logic [pst_pkg::PID_W-1:0]     pid_ff, pid_in;
   logic [pst_pkg::IDX_W-1:0]     idx_ff, idx_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [CNT_W-1:0]              rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]              pend_ptr_ff, pend_ptr_in;
   logic                          pend_ff, pend_in;
   logic                          found_ff, found_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_was_present_ff, rsp_was_present_in;
   logic                          rsp_rejected_full_ff, rsp_rejected_full_in;
   logic [pst_pkg::CNT_OUT_W-1:0] rsp_entry_count_ff, rsp_entry_count_in;
   logic [pst_pkg::PID_W-1:0]     rsp_read_value_ff, rsp_read_value_in;
   logic                          rsp_read_valid_ff, rsp_read_valid_in;

   logic                          ram_wr_en;
   logic [AW-1:0]                 ram_wr_addr;
   logic [pst_pkg::PID_W-1:0]     ram_wr_data;
   logic [AW-1:0]                 ram_rd_addr;
   logic [pst_pkg::PID_W-1:0]     ram_rd_data;

   logic                          accept;
   logic                          issue;
   logic                          hit;
   logic                          scan_done;
   logic                          shift_done;
   logic                          full;
   logic                          read_ok;
   logic [CMP_W-1:0]              idx_ext;
   logic [CMP_W-1:0]              count_ext;
   logic [CNT_W+pst_pkg::CNT_OUT_W-1:0] count_out_ext;

   pst_ram #(
      .WIDTH  (pst_pkg::PID_W),
      .DEPTH  (MAX_ENTRIES),
      .ADDR_W (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign busy       = (state_ff != pst_pkg::ST_IDLE);
   assign accept     = start && !busy;
   assign issue      = (rd_ptr_ff < count_ff);
   assign hit        = pend_ff && (ram_rd_data == pid_ff);
   assign scan_done  = hit || (!issue && !pend_ff);
   assign shift_done = !issue && !pend_ff;
   assign full       = (count_ff == CNT_W'(MAX_ENTRIES));
   assign idx_ext    = {{CNT_W{1'b0}}, idx_ff};
   assign count_ext  = {{pst_pkg::IDX_W{1'b0}}, count_ff};
   assign read_ok    = (idx_ext < count_ext);
   assign count_out_ext = {{pst_pkg::CNT_OUT_W{1'b0}}, count_in};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pst_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = pst_pkg::ST_SCAN;
            end
         end
         pst_pkg::ST_SCAN: begin
            if (scan_done) begin
               if (op_ff == pst_pkg::OP_REMOVE && hit) begin
                  state_in = pst_pkg::ST_SHIFT;
               end else if (op_ff == pst_pkg::OP_READ) begin
                  state_in = pst_pkg::ST_RD_WAIT;
               end else begin
                  state_in = pst_pkg::ST_FINISH;
               end
            end
         end
         pst_pkg::ST_SHIFT: begin
            if (shift_done) begin
               state_in = pst_pkg::ST_FINISH;
            end
         end
         pst_pkg::ST_RD_WAIT: begin
            state_in = pst_pkg::ST_FINISH;
         end
         pst_pkg::ST_FINISH: begin
            state_in = pst_pkg::ST_IDLE;
         end
         default: begin
            state_in = pst_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      op_in       = op_ff;
      pid_in      = pid_ff;
      idx_in      = idx_ff;
      count_in    = count_ff;
      rd_ptr_in   = rd_ptr_ff;
      pend_ptr_in = pend_ptr_ff;
      pend_in     = 1'b0;
      found_in    = found_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = pend_ptr_ff[AW-1:0];
      ram_wr_data = ram_rd_data;
      ram_rd_addr = rd_ptr_ff[AW-1:0];

      rsp_valid_in         = 1'b0;
      rsp_was_present_in   = rsp_was_present_ff;
      rsp_rejected_full_in = rsp_rejected_full_ff;
      rsp_entry_count_in   = rsp_entry_count_ff;
      rsp_read_value_in    = rsp_read_value_ff;
      rsp_read_valid_in    = rsp_read_valid_ff;

      unique case (state_ff)
         pst_pkg::ST_IDLE: begin
            if (accept) begin
               op_in     = pst_pkg::op_type'(req_opcode);
               pid_in    = req_pid;
               idx_in    = req_entry_index;
               rd_ptr_in = '0;
               found_in  = 1'b0;
            end
         end
         pst_pkg::ST_SCAN: begin
            if (issue) begin
               rd_ptr_in = rd_ptr_ff + 1'b1;
            end
            pend_in     = issue;
            pend_ptr_in = rd_ptr_ff;
            if (scan_done) begin
               found_in    = hit;
               pend_in     = 1'b0;
               pend_ptr_in = pend_ptr_ff;
               rd_ptr_in   = pend_ptr_ff + 1'b1;
            end
         end
         pst_pkg::ST_SHIFT: begin
            if (issue) begin
               rd_ptr_in = rd_ptr_ff + 1'b1;
            end
            pend_in     = issue;
            pend_ptr_in = rd_ptr_ff;
            if (pend_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = AW'(pend_ptr_ff - 1'b1);
               ram_wr_data = ram_rd_data;
            end
         end
         pst_pkg::ST_RD_WAIT: begin
            ram_rd_addr = idx_ext[AW-1:0];
         end
         pst_pkg::ST_FINISH: begin
            rsp_valid_in         = 1'b1;
            rsp_was_present_in   = found_ff;
            rsp_rejected_full_in = 1'b0;
            rsp_read_value_in    = '0;
            rsp_read_valid_in    = 1'b0;
            case (op_ff)
               pst_pkg::OP_ADD: begin
                  if (!found_ff) begin
                     if (full) begin
                        rsp_rejected_full_in = 1'b1;
                     end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = count_ff[AW-1:0];
                        ram_wr_data = pid_ff;
                        count_in    = count_ff + 1'b1;
                     end
                  end
               end
               pst_pkg::OP_REMOVE: begin
                  if (found_ff) begin
                     count_in = count_ff - 1'b1;
                  end
               end
               pst_pkg::OP_READ: begin
                  if (read_ok) begin
                     rsp_read_value_in = ram_rd_data;
                     rsp_read_valid_in = 1'b1;
                  end
               end
               default: begin
               end
            endcase
            rsp_entry_count_in = count_out_ext[pst_pkg::CNT_OUT_W-1:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pst_pkg::ST_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff                <= op_in;
      pid_ff               <= pid_in;
      idx_ff               <= idx_in;
      rd_ptr_ff            <= rd_ptr_in;
      pend_ptr_ff          <= pend_ptr_in;
      found_ff             <= found_in;
      rsp_was_present_ff   <= rsp_was_present_in;
      rsp_rejected_full_ff <= rsp_rejected_full_in;
      rsp_entry_count_ff   <= rsp_entry_count_in;
      rsp_read_value_ff    <= rsp_read_value_in;
      rsp_read_valid_ff    <= rsp_read_valid_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_was_present   = rsp_was_present_ff;
   assign rsp_rejected_full = rsp_rejected_full_ff;
   assign rsp_entry_count   = rsp_entry_count_ff;
   assign rsp_read_value    = rsp_read_value_ff;
   assign rsp_read_valid    = rsp_read_valid_ff;

endmodule

`default_nettype wire

### dv/pid_set_table_tb.sv
// ----------------------------------------------------------------------------
// PID set table testbench
// Drives lookup, add, remove and indexed read commands into the PID set table
// and keeps a shadow copy of the ordered set that predicts every result beat.
// A short directed run covers the empty, duplicate, absent, first and last
// entry cases; random runs then alternate epochs that fill the table towards
// its limit and drain it again, with random gaps between commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pid_set_table_tb;
   import pst_pkg::*;

   localparam int TABLE_DEPTH   = DEFAULT_MAX_ENTRIES;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 16;
   localparam int EPOCHS        = 6;
   localparam int EPOCH_LEN     = 75;
   localparam int POOL_SIZE     = 48;

   typedef struct packed {
      logic                 was_present;
      logic                 rejected_full;
      logic [CNT_OUT_W-1:0] entry_count;
      logic [PID_W-1:0]     read_value;
      logic                 read_valid;
   } reply_type;

   class pid_table_shadow_type;
      logic [PID_W-1:0] entries [TABLE_DEPTH];
      int unsigned      count;
      reply_type        pending_replies [$];
      int unsigned      mismatches;

      function new();
         count      = 0;
         mismatches = 0;
      endfunction

      function void note_request(op_type op, logic [PID_W-1:0] pid,
                                 logic [IDX_W-1:0] idx);
         reply_type   r;
         int unsigned pos;
         int unsigned i;
         r   = '0;
         pos = count;
         for (i = 0; i < count; i++) begin
            if (pos == count && entries[i] == pid) begin
               pos = i;
            end
         end
         r.was_present = (pos < count);
         case (op)
            OP_ADD: begin
               if (!r.was_present) begin
                  if (count < TABLE_DEPTH) begin
                     entries[count] = pid;
                     count++;
                  end else begin
                     r.rejected_full = 1'b1;
                  end
               end
            end
            OP_REMOVE: begin
               if (r.was_present) begin
                  for (i = pos; i + 1 < count; i++) begin
                     entries[i] = entries[i + 1];
                  end
                  count--;
               end
            end
            OP_READ: begin
               if (idx < count) begin
                  r.read_value = entries[idx];
                  r.read_valid = 1'b1;
               end
            end
            default: begin
            end
         endcase
         r.entry_count = CNT_OUT_W'(count);
         pending_replies.push_back(r);
      endfunction

      function void compare_field(string field, logic [15:0] want, logic [15:0] got);
         if (want !== got) begin
            $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, field, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(reply_type got);
         reply_type want;
         if (pending_replies.size() == 0) begin
            $display("%0t: result beat with no command outstanding", $time);
            mismatches++;
         end else begin
            want = pending_replies.pop_front();
            compare_field("was_present", 16'(want.was_present), 16'(got.was_present));
            compare_field("rejected_full", 16'(want.rejected_full),
                          16'(got.rejected_full));
            compare_field("entry_count", 16'(want.entry_count), 16'(got.entry_count));
            compare_field("read_value", 16'(want.read_value), 16'(got.read_value));
            compare_field("read_valid", 16'(want.read_valid), 16'(got.read_valid));
         end
      endfunction
   endclass

   logic                 clock           = 1'b0;
   logic                 reset           = 1'b1;
   logic                 start           = 1'b0;
   logic [OP_W-1:0]      req_opcode      = '0;
   logic [PID_W-1:0]     req_pid         = '0;
   logic [IDX_W-1:0]     req_entry_index = '0;
   logic                 busy;
   logic                 rsp_valid;
   logic                 rsp_was_present;
   logic                 rsp_rejected_full;
   logic [CNT_OUT_W-1:0] rsp_entry_count;
   logic [PID_W-1:0]     rsp_read_value;
   logic                 rsp_read_valid;

   pid_table_shadow_type tracker = new();
   logic [PID_W-1:0]     pid_pool [POOL_SIZE];
   bit                   no_gaps = 1'b0;
   int unsigned          cycles  = 0;

   pid_set_table dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_pid           (req_pid),
      .req_entry_index   (req_entry_index),
      .rsp_valid         (rsp_valid),
      .rsp_was_present   (rsp_was_present),
      .rsp_rejected_full (rsp_rejected_full),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_read_value    (rsp_read_value),
      .rsp_read_valid    (rsp_read_valid)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("pid_set_table_tb: done, errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         tracker.check_result('{rsp_was_present, rsp_rejected_full, rsp_entry_count,
                                rsp_read_value, rsp_read_valid});
      end
   end

   // A command beat is taken at the first edge with start high and busy low.
   task automatic send_request(input op_type op, input logic [PID_W-1:0] pid,
                               input logic [IDX_W-1:0] idx);
      int unsigned gap;
      gap = no_gaps ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_opcode      <= op;
      req_pid         <= pid;
      req_entry_index <= idx;
      do @(posedge clock); while (busy);
      tracker.note_request(op, pid, idx);
   endtask

   // Filling runs favour adds of new PIDs so that the table reaches its limit;
   // draining runs favour removes of stored PIDs.
   task automatic run_epoch(input bit filling);
      int unsigned      roll;
      int unsigned      table_weight;
      op_type           op;
      logic [PID_W-1:0] pid;
      logic [IDX_W-1:0] idx;
      table_weight = filling ? 2 : 7;
      for (int n = 0; n < EPOCH_LEN; n++) begin
         roll = $urandom_range(0, 99);
         if (filling) begin
            if (roll < 70) op = OP_ADD;
            else if (roll < 80) op = OP_LOOKUP;
            else if (roll < 95) op = OP_READ;
            else op = OP_REMOVE;
         end else begin
            if (roll < 60) op = OP_REMOVE;
            else if (roll < 75) op = OP_ADD;
            else if (roll < 85) op = OP_LOOKUP;
            else op = OP_READ;
         end
         roll = $urandom_range(0, 9);
         if (roll < table_weight && tracker.count > 0) begin
            pid = tracker.entries[$urandom_range(0, tracker.count - 1)];
         end else if (roll < 6) begin
            pid = pid_pool[$urandom_range(0, POOL_SIZE - 1)];
         end else begin
            pid = PID_W'($urandom);
         end
         if ($urandom_range(0, 9) < 7) begin
            idx = IDX_W'($urandom_range(0, tracker.count < TABLE_DEPTH ?
                                           tracker.count : TABLE_DEPTH - 1));
         end else begin
            idx = IDX_W'($urandom);
         end
         send_request(op, pid, idx);
      end
   endtask

   initial begin
      pid_pool[0] = '0;
      pid_pool[1] = '1;
      for (int k = 2; k < POOL_SIZE; k++) begin
         pid_pool[k] = PID_W'($urandom);
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_request(OP_LOOKUP, 13'h0000, 5'd31);
      send_request(OP_READ,   13'h0000, 5'd0);
      send_request(OP_ADD,    13'h0000, 5'd0);
      send_request(OP_ADD,    13'h1FFF, 5'd31);
      send_request(OP_ADD,    13'h1FFF, 5'd0);
      send_request(OP_LOOKUP, 13'h1FFF, 5'd0);
      send_request(OP_LOOKUP, 13'h1000, 5'd0);
      send_request(OP_READ,   13'h1000, 5'd0);
      send_request(OP_READ,   13'h0000, 5'd1);
      send_request(OP_READ,   13'h0000, 5'd2);
      send_request(OP_READ,   13'h1FFF, 5'd31);
      send_request(OP_REMOVE, 13'h1000, 5'd0);
      send_request(OP_ADD,    13'h0AAA, 5'd0);
      send_request(OP_ADD,    13'h1555, 5'd0);
      send_request(OP_REMOVE, 13'h0000, 5'd0);
      send_request(OP_READ,   13'h0AAA, 5'd0);
      send_request(OP_READ,   13'h0000, 5'd1);
      send_request(OP_READ,   13'h0000, 5'd2);
      send_request(OP_REMOVE, 13'h1555, 5'd0);
      send_request(OP_REMOVE, 13'h1FFF, 5'd0);
      send_request(OP_REMOVE, 13'h0AAA, 5'd0);
      send_request(OP_LOOKUP, 13'h0AAA, 5'd31);

      for (int e = 0; e < EPOCHS; e++) begin
         no_gaps = (e % 3 == 1);
         run_epoch(e % 2 == 0);
      end
      start <= 1'b0;

      while (tracker.pending_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0) begin
         $display("pid_set_table_tb: done, clean");
      end else begin
         $display("pid_set_table_tb: done, errors");
      end
      $finish;
   end

endmodule
